// ===== rtl/cma_pkg.sv =====
// Package: types and codes for the contiguous memory allocator.
`timescale 1ns / 1ps
`default_nettype none
package cma_pkg;
	localparam int SIZE_W = 21;
	localparam int STAT_W = 2;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NO_HOLE = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_t;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_PLACE,
		S_FREE,
		S_MERGE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  owner_id;
		logic [20:0] alloc_size;
		logic [1:0]  fit_mode;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [19:0] alloc_start;
	} result_t;
endpackage
`default_nettype wire

// ===== rtl/contiguous_memory_allocator.sv =====
// Top level: contiguous segment allocator with first, best and worst fit.
// An allocation scans every entry in use, then decides: a grant without split goes to place, a
// split grant first shifts the entries above the pick up and writes the remainder, and no hole or
// a full table goes to done. A release frees and merges in one pass; a zero-size request
// goes straight to done. One request at a time: busy stays high through the done cycle, so a
// new request is accepted only once the last one is through; a config write passes through init.
// Reset: the init state loads one free segment of 2^ADDR_WIDTH; receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module contiguous_memory_allocator #(
	parameter int MAX_SEGMENTS = 16,
	parameter int ADDR_WIDTH   = 20,
	parameter int ID_WIDTH     = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire cma_pkg::cmd_t        cmd,
	output logic                      done,
	output cma_pkg::result_t          result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [20:0]          cfg_data
);
	localparam int XW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int LW = ADDR_WIDTH + 1;
	// request size keeps all of its bits even when lengths are narrower
	localparam int SW = (LW > cma_pkg::SIZE_W) ? LW : cma_pkg::SIZE_W;
	localparam logic [LW-1:0] SPAN = LW'(1) << ADDR_WIDTH;

	cma_pkg::state_t state_q, state_d;

	logic [LW-1:0] total_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;      // scan / read index
	logic [CW-1:0] wr_q;       // merge write index
	logic          pick_v_q;
	logic [XW-1:0] pick_q;
	logic [LW-1:0] pick_len_q;
	logic          kind_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [SW-1:0] size_q;
	logic [1:0]    mode_q;
	// merge carry: last written entry (w-1)
	logic          prev_free_q;
	logic [ADDR_WIDTH-1:0] prev_base_q;
	logic [LW-1:0] prev_len_q;
	logic [1:0]    stat_q;
	logic [ADDR_WIDTH-1:0] astart_q;

	// table port
	logic          t_init, t_we, t_wtaken, t_rtaken;
	logic [XW-1:0] t_waddr, t_raddr;
	logic [ADDR_WIDTH-1:0] t_wbase, t_rbase;
	logic [LW-1:0] t_wlen, t_rlen;
	logic [ID_WIDTH-1:0] t_wowner, t_rowner;

	cma_seg_table #(
		.DEPTH(MAX_SEGMENTS), .AW(ADDR_WIDTH), .IW(ID_WIDTH), .LW(LW), .XW(XW)
	) u_tab (
		.clk(clk), .arst_n(arst_n), .init(t_init), .init_len(total_q),
		.we(t_we), .waddr(t_waddr), .wbase(t_wbase), .wlen(t_wlen),
		.wowner(t_wowner), .wtaken(t_wtaken), .raddr(t_raddr),
		.rbase(t_rbase), .rlen(t_rlen), .rowner(t_rowner), .rtaken(t_rtaken)
	);

	// clamp written size to [1, 2^ADDR_WIDTH]
	logic [LW-1:0] cfg_clamp;
	always_comb begin
		priority if (cfg_data == '0) cfg_clamp = LW'(1);
		else if (33'(cfg_data) > 33'(SPAN)) cfg_clamp = SPAN;
		else cfg_clamp = LW'(cfg_data);
	end

	wire accept  = start && !busy;
	wire cfg_fire = cfg_valid && cfg_ready;
	assign cfg_ready = (state_q == cma_pkg::S_IDLE) && !start;
	assign busy = (state_q != cma_pkg::S_IDLE);

	// shared comparator: candidate length against request / current pick
	wire fits     = !t_rtaken && (SW'(t_rlen) >= size_q);
	wire better   = (mode_q == cma_pkg::FIT_BEST)  ? (t_rlen < pick_len_q) :
	                (mode_q == cma_pkg::FIT_WORST) ? (t_rlen > pick_len_q) : 1'b0;
	wire scan_end = (idx_q >= count_q) || (idx_q >= CW'(MAX_SEGMENTS));
	wire split    = pick_len_q != LW'(size_q);
	wire [CW-1:0] pick_x = CW'(pick_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cma_pkg::S_IDLE: begin
				if (cfg_fire) state_d = cma_pkg::S_INIT;
				else if (accept) begin
					if (cmd.kind == cma_pkg::KIND_RELEASE) state_d = cma_pkg::S_FREE;
					else if (cmd.alloc_size == '0) state_d = cma_pkg::S_DONE;
					else state_d = cma_pkg::S_SCAN;
				end
			end
			cma_pkg::S_INIT:   state_d = cma_pkg::S_IDLE;
			cma_pkg::S_SCAN:   if (scan_end) state_d = cma_pkg::S_DECIDE;
			cma_pkg::S_DECIDE: begin
				if (!pick_v_q) state_d = cma_pkg::S_DONE;
				else if (split && count_q >= CW'(MAX_SEGMENTS)) state_d = cma_pkg::S_DONE;
				else if (split) state_d = cma_pkg::S_SHIFT;
				else state_d = cma_pkg::S_PLACE;
			end
			cma_pkg::S_SHIFT:  if (idx_q <= pick_x + CW'(1)) state_d = cma_pkg::S_PLACE;
			cma_pkg::S_PLACE:  state_d = cma_pkg::S_DONE;
			cma_pkg::S_FREE:   if (scan_end) state_d = cma_pkg::S_DONE;
			cma_pkg::S_MERGE:  state_d = cma_pkg::S_DONE;
			cma_pkg::S_DONE:   state_d = cma_pkg::S_IDLE;
			default:           state_d = cma_pkg::S_IDLE;
		endcase
	end

	// release runs free+merge in one pass: entry r is freed if its owner matches,
	// and merged into w-1 when both are free.
	wire r_taken = t_rtaken && !(t_rowner == id_q);

	// table control
	always_comb begin
		t_init   = (state_q == cma_pkg::S_INIT);
		t_we     = 1'b0;
		t_waddr  = '0;
		t_wbase  = t_rbase;
		t_wlen   = t_rlen;
		t_wowner = t_rowner;
		t_wtaken = t_rtaken;
		t_raddr  = XW'(idx_q);
		unique case (state_q)
			cma_pkg::S_SHIFT: begin
				// copy idx-1 to idx, or write the split remainder at pick+1
				if (idx_q > pick_x + CW'(1)) begin
					t_raddr = XW'(idx_q - CW'(1));
					t_we    = 1'b1;
					t_waddr = XW'(idx_q);
				end else begin
					t_raddr  = pick_q;
					t_we     = 1'b1;
					t_waddr  = XW'(idx_q);
					t_wbase  = t_rbase + ADDR_WIDTH'(size_q);
					t_wlen   = pick_len_q - LW'(size_q);
					t_wtaken = 1'b0;
				end
			end
			cma_pkg::S_PLACE: begin
				t_raddr  = pick_q;
				t_we     = 1'b1;
				t_waddr  = pick_q;
				t_wlen   = LW'(size_q);
				t_wowner = id_q;
				t_wtaken = 1'b1;
			end
			cma_pkg::S_FREE: begin
				if (!scan_end) begin
					t_we = 1'b1;
					if (wr_q != '0 && prev_free_q && !r_taken) begin
						t_waddr  = XW'(wr_q - CW'(1));
						t_wbase  = prev_base_q;
						t_wlen   = prev_len_q + t_rlen;
						t_wtaken = 1'b0;
					end else begin
						t_waddr  = XW'(wr_q);
						t_wtaken = r_taken;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cma_pkg::S_INIT;
			total_q  <= SPAN;
			count_q  <= CW'(1);
			idx_q    <= '0;
			wr_q     <= '0;
			pick_v_q <= 1'b0;
			stat_q   <= cma_pkg::ST_DONE;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				cma_pkg::S_IDLE: begin
					idx_q    <= '0;
					wr_q     <= '0;
					pick_v_q <= 1'b0;
					if (cfg_fire) total_q <= cfg_clamp;
					if (accept && cmd.kind == cma_pkg::KIND_ALLOC && cmd.alloc_size == '0)
						stat_q <= cma_pkg::ST_NO_HOLE;
					else
						stat_q <= cma_pkg::ST_DONE;
				end
				cma_pkg::S_INIT: count_q <= CW'(1);
				cma_pkg::S_SCAN: begin
					if (!scan_end) begin
						if (fits && (!pick_v_q || better)) begin
							pick_v_q <= 1'b1;
							pick_q   <= XW'(idx_q);
						end
						idx_q <= idx_q + CW'(1);
					end
				end
				cma_pkg::S_DECIDE: begin
					idx_q <= count_q;
					if (!pick_v_q) stat_q <= cma_pkg::ST_NO_HOLE;
					else if (split && count_q >= CW'(MAX_SEGMENTS)) stat_q <= cma_pkg::ST_FULL;
				end
				cma_pkg::S_SHIFT: begin
					idx_q <= idx_q - CW'(1);
					if (idx_q <= pick_x + CW'(1)) count_q <= count_q + CW'(1);
				end
				cma_pkg::S_FREE: begin
					if (!scan_end) begin
						idx_q <= idx_q + CW'(1);
						if (wr_q != '0 && prev_free_q && !r_taken) begin
							prev_len_q <= prev_len_q + t_rlen;
						end else begin
							wr_q        <= wr_q + CW'(1);
							prev_free_q <= !r_taken;
							prev_base_q <= t_rbase;
							prev_len_q  <= t_rlen;
						end
					end else begin
						count_q <= wr_q;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= cmd.kind;
			id_q   <= ID_WIDTH'(cmd.owner_id);
			size_q <= SW'(cmd.alloc_size);
			mode_q <= (cmd.fit_mode == 2'd3) ? cma_pkg::FIT_FIRST : cmd.fit_mode;
		end
		if (state_q == cma_pkg::S_SCAN && !scan_end && fits && (!pick_v_q || better))
			pick_len_q <= t_rlen;
		if (state_q == cma_pkg::S_IDLE) astart_q <= '0;
		else if (state_q == cma_pkg::S_PLACE) astart_q <= t_rbase;
	end

	always_comb begin
		done               = (state_q == cma_pkg::S_DONE);
		result.status      = done ? stat_q : 2'd0;
		result.alloc_start = done ? 20'(astart_q) : '0;
	end

	// a table write never happens while idle
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cma_pkg::S_IDLE |-> !t_we) else $error("idle table write");
	// segment count stays within table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SEGMENTS) && count_q != '0) else $error("count out of range");
	// done lasts one cycle and follows busy work
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	// release never reports failure
	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && kind_q == cma_pkg::KIND_RELEASE |-> result.status == cma_pkg::ST_DONE)
		else $error("release failed");
endmodule
`default_nettype wire

// ===== rtl/cma_seg_table.sv =====
// Segment table: base, length, owner and taken flag per entry, flop based.
`timescale 1ns / 1ps
`default_nettype none
module cma_seg_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 20,
	parameter int IW    = 8,
	parameter int LW    = 21,
	parameter int XW    = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          init,
	input  wire logic [LW-1:0] init_len,
	input  wire logic          we,
	input  wire logic [XW-1:0] waddr,
	input  wire logic [AW-1:0] wbase,
	input  wire logic [LW-1:0] wlen,
	input  wire logic [IW-1:0] wowner,
	input  wire logic          wtaken,
	input  wire logic [XW-1:0] raddr,
	output logic      [AW-1:0] rbase,
	output logic      [LW-1:0] rlen,
	output logic      [IW-1:0] rowner,
	output logic               rtaken
);
	logic [AW-1:0] base_q  [DEPTH];
	logic [LW-1:0] len_q   [DEPTH];
	logic [IW-1:0] owner_q [DEPTH];
	logic [DEPTH-1:0] taken_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else if (init) begin
			taken_q <= '0;
		end else if (we) begin
			taken_q[waddr] <= wtaken;
		end
	end

	// entry 0 reset values come via init pulse issued after reset
	always_ff @(posedge clk) begin
		if (init) begin
			base_q[0] <= '0;
			len_q[0]  <= init_len;
		end else if (we) begin
			base_q[waddr]  <= wbase;
			len_q[waddr]   <= wlen;
			owner_q[waddr] <= wowner;
		end
	end

	assign rbase  = base_q[raddr];
	assign rlen   = len_q[raddr];
	assign rowner = owner_q[raddr];
	assign rtaken = taken_q[raddr];
endmodule
`default_nettype wire
